### rtl/pctc_pkg.sv
// Shared types and constants for the partial-correlation to Cholesky streamer.
// No dependencies; used by pctc_sqrt, pctc_mul and the top level.
`timescale 1ns / 1ps

package pctc_pkg;

    localparam int FRAC_BITS  = 30;
    localparam int MAX_DIM    = 64;
    localparam int DATA_W     = 32;
    localparam int DIM_W      = 7;
    localparam int IDX_W      = 6;
    localparam int SUM_W      = 32;
    localparam int ROOT_W     = FRAC_BITS + 1;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int PROD_W     = 2 * ROOT_W;
    localparam int SQRT_CNT_W = $clog2(ROOT_W);

    localparam int DIM_LIM_I = (MAX_DIM < 64) ? MAX_DIM : 64;

    localparam logic [DIM_W-1:0] DIM_MIN = DIM_W'(2);
    localparam logic [DIM_W-1:0] DIM_LIM = DIM_W'(DIM_LIM_I);

    // 1.0 and 2.0 in the row-sum format
    localparam logic [SUM_W-1:0] ONE_SUM = SUM_W'(1) << FRAC_BITS;
    localparam logic [SUM_W-1:0] TWO_SUM = SUM_W'(2) << FRAC_BITS;

    typedef struct packed {
        logic [DIM_W-1:0] dimension;
    } cfg_data_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] z_value;
    } z_data_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] factor_value;
        logic [IDX_W-1:0]         row_index;
        logic [IDX_W-1:0]         col_index;
        logic                     last_of_run;
        logic                     matrix_done;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ORIGIN,
        ST_ROOT,
        ST_ROOT_WAIT,
        ST_MUL_E,
        ST_EMIT_E,
        ST_MUL_SQ,
        ST_ACC,
        ST_DIAG_ROOT,
        ST_DIAG_WAIT,
        ST_EMIT_D
    } state_t;

endpackage

### rtl/pctc_chan_if.sv
// Valid/ready channel carrying one payload type.
// Payload types come from pctc_pkg.
`timescale 1ns / 1ps

interface pctc_chan_if #(
    parameter type data_t = logic
) ();
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/pctc_sqrt.sv
// Restoring bit-serial square root: floor(sqrt(operand * 2^FRAC_BITS)).
// One root bit per cycle; depends on pctc_pkg.
`timescale 1ns / 1ps

module pctc_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pctc_pkg::ROOT_W-1:0] operand,
    output logic                       done,
    output logic [pctc_pkg::ROOT_W-1:0] root
);

    logic [pctc_pkg::RAD_W-1:0]      rad_reg;
    logic [pctc_pkg::ROOT_W+1:0]     rem_reg;
    logic [pctc_pkg::ROOT_W-1:0]     root_reg;
    logic [pctc_pkg::SQRT_CNT_W-1:0] count_reg;
    logic                            busy_reg;
    logic                            done_reg;

    logic [pctc_pkg::ROOT_W+3:0] rem_shift;
    logic [pctc_pkg::ROOT_W+3:0] trial;
    logic                        fits;
    logic [pctc_pkg::ROOT_W+1:0] rem_next;
    logic [pctc_pkg::ROOT_W-1:0] root_next;

    always_comb
    begin
        rem_shift = {rem_reg, rad_reg[pctc_pkg::RAD_W-1 -: 2]};
        trial     = (pctc_pkg::ROOT_W+4)'({root_reg, 2'b01});
        fits      = (rem_shift >= trial);
        rem_next  = fits ? (pctc_pkg::ROOT_W+2)'(rem_shift - trial)
                         : rem_shift[pctc_pkg::ROOT_W+1:0];
        root_next = {root_reg[pctc_pkg::ROOT_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            count_reg <= pctc_pkg::SQRT_CNT_W'(pctc_pkg::ROOT_W - 1);
        end
        else if (busy_reg)
        begin
            if (count_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= {1'b0, operand, {pctc_pkg::FRAC_BITS{1'b0}}};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[pctc_pkg::RAD_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### rtl/pctc_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on pctc_pkg for operand widths.
`timescale 1ns / 1ps

module pctc_mul (
    input  logic                        clk,
    input  logic                        en,
    input  logic [pctc_pkg::ROOT_W-1:0] a,
    input  logic [pctc_pkg::ROOT_W-1:0] b,
    output logic [pctc_pkg::PROD_W-1:0] prod
);

    logic [pctc_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= pctc_pkg::PROD_W'(a) * pctc_pkg::PROD_W'(b);
        end
    end

    assign prod = prod_reg;

endmodule

### rtl/partial_correlation_to_cholesky.sv
// Top level: turns a stream of partial correlations into Cholesky factor entries.
// Depends on pctc_pkg, pctc_chan_if, pctc_sqrt and pctc_mul.
`timescale 1ns / 1ps

// Channel     Dir   Payload                                        Transfer when
// ---------   ---   --------------------------------------------   ------------------
// cfg         in    dimension (7b)                                  valid & ready
// z_stream    in    z_value (s32, Q1.30)                            valid & ready
// result      out   factor_value, row_index, col_index,             valid & ready
//                   last_of_run, matrix_done
//
// Off-diagonal input: the square root of the row budget is taken, |z| times the
// root is loaded into the output register, its square is added to the row sum,
// and only then is the next input transfer possible. A row's last column runs a
// second square root and loads the diagonal. L(0,0) is loaded first in a matrix.
// Square root: bit-serial, 31 root bits, one per cycle. An emit step waits while
// a result is still untaken. Reset: P = 2, row 1 column 0, sum zero, L(0,0) due.

module partial_correlation_to_cholesky (
    input  logic        clk,
    input  logic        rst_n,
    pctc_chan_if.sink   cfg,
    pctc_chan_if.sink   z_stream,
    pctc_chan_if.source result
);

    pctc_pkg::state_t state_reg, state_next;

    logic [pctc_pkg::DIM_W-1:0] dim_reg;
    logic [pctc_pkg::SUM_W-1:0] row_sum_reg, row_sum_next;
    logic [pctc_pkg::IDX_W-1:0] cur_row_reg, cur_row_next;
    logic [pctc_pkg::IDX_W-1:0] cur_col_reg, cur_col_next;
    logic                       origin_sent_reg, origin_sent_next;

    // magnitude and sign of the accepted z
    logic                        neg_reg;
    logic [pctc_pkg::ROOT_W-1:0] mag_reg;

    logic                out_valid_reg;
    pctc_pkg::result_t   out_data_reg;
    logic                out_load;
    pctc_pkg::result_t   out_data_next;
    logic                out_free;

    logic                        sqrt_start;
    logic [pctc_pkg::ROOT_W-1:0] sqrt_operand;
    logic                        sqrt_done;
    logic [pctc_pkg::ROOT_W-1:0] sqrt_root;

    logic                        mul_en;
    logic [pctc_pkg::ROOT_W-1:0] mul_a;
    logic [pctc_pkg::ROOT_W-1:0] mul_b;
    logic [pctc_pkg::PROD_W-1:0] mul_prod;

    logic [pctc_pkg::DIM_W-1:0]  dim_eff;
    logic                        row_end;
    logic                        mat_end;
    logic [pctc_pkg::ROOT_W-1:0] budget;
    logic [pctc_pkg::ROOT_W-1:0] prod_q;
    logic [pctc_pkg::SUM_W:0]    sum_wide;
    logic [pctc_pkg::DATA_W-1:0] entry_val;
    logic [pctc_pkg::DATA_W-1:0] z_abs;
    logic                        z_accept;

    // ------------------------------------------------------------------
    // Shared units
    // ------------------------------------------------------------------
    pctc_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sqrt_start),
        .operand (sqrt_operand),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    pctc_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    assign cfg.ready = 1'b1;
    assign z_stream.ready = (state_reg == pctc_pkg::ST_IDLE);
    assign z_accept = z_stream.valid && z_stream.ready;

    // out-of-range dimension is clamped
    always_comb
    begin
        priority if (dim_reg < pctc_pkg::DIM_MIN)
            dim_eff = pctc_pkg::DIM_MIN;
        else if (dim_reg > pctc_pkg::DIM_LIM)
            dim_eff = pctc_pkg::DIM_LIM;
        else
            dim_eff = dim_reg;
    end

    assign row_end = ({1'b0, cur_col_reg} + 1'b1) >= {1'b0, cur_row_reg};
    assign mat_end = ({1'b0, cur_row_reg} + 1'b1) >= dim_eff;

    // row budget max(0, 1 - sum)
    assign budget = (row_sum_reg < pctc_pkg::ONE_SUM)
                  ? pctc_pkg::ROOT_W'(pctc_pkg::ONE_SUM - row_sum_reg) : '0;

    // truncated Q1.30 product; operands never exceed 1.0
    assign prod_q    = mul_prod[pctc_pkg::FRAC_BITS +: pctc_pkg::ROOT_W];
    assign sum_wide  = {1'b0, row_sum_reg} + (pctc_pkg::SUM_W+1)'(prod_q);
    assign entry_val = neg_reg ? (pctc_pkg::DATA_W'(0) - pctc_pkg::DATA_W'(prod_q))
                               : pctc_pkg::DATA_W'(prod_q);

    assign z_abs = z_stream.data.z_value[pctc_pkg::DATA_W-1]
                 ? (pctc_pkg::DATA_W'(0) - z_stream.data.z_value)
                 : z_stream.data.z_value;

    assign out_free = !out_valid_reg || result.ready;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        row_sum_next     = row_sum_reg;
        cur_row_next     = cur_row_reg;
        cur_col_next     = cur_col_reg;
        origin_sent_next = origin_sent_reg;
        out_load         = 1'b0;
        out_data_next    = out_data_reg;
        sqrt_start       = 1'b0;
        sqrt_operand     = budget;
        mul_en           = 1'b0;
        mul_a            = mag_reg;
        mul_b            = sqrt_root;

        unique case (state_reg)
            pctc_pkg::ST_IDLE:
            begin
                if (z_accept)
                    state_next = origin_sent_reg ? pctc_pkg::ST_ROOT : pctc_pkg::ST_ORIGIN;
            end
            pctc_pkg::ST_ORIGIN:
            begin
                // L(0,0) = 1 opens each matrix
                if (out_free)
                begin
                    out_load                   = 1'b1;
                    out_data_next.factor_value = $signed(pctc_pkg::ONE_SUM);
                    out_data_next.row_index    = '0;
                    out_data_next.col_index    = '0;
                    out_data_next.last_of_run  = 1'b0;
                    out_data_next.matrix_done  = 1'b0;
                    origin_sent_next           = 1'b1;
                    state_next                 = pctc_pkg::ST_ROOT;
                end
            end
            pctc_pkg::ST_ROOT:
            begin
                sqrt_start = 1'b1;
                state_next = pctc_pkg::ST_ROOT_WAIT;
            end
            pctc_pkg::ST_ROOT_WAIT:
            begin
                if (sqrt_done)
                    state_next = pctc_pkg::ST_MUL_E;
            end
            pctc_pkg::ST_MUL_E:
            begin
                // e = |z| * root
                mul_en     = 1'b1;
                state_next = pctc_pkg::ST_EMIT_E;
            end
            pctc_pkg::ST_EMIT_E:
            begin
                if (out_free)
                begin
                    out_load                   = 1'b1;
                    out_data_next.factor_value = $signed(entry_val);
                    out_data_next.row_index    = cur_row_reg;
                    out_data_next.col_index    = cur_col_reg;
                    out_data_next.last_of_run  = !row_end;
                    out_data_next.matrix_done  = 1'b0;
                    state_next                 = pctc_pkg::ST_MUL_SQ;
                end
            end
            pctc_pkg::ST_MUL_SQ:
            begin
                // e * e, from the product register itself
                mul_en     = 1'b1;
                mul_a      = prod_q;
                mul_b      = prod_q;
                state_next = pctc_pkg::ST_ACC;
            end
            pctc_pkg::ST_ACC:
            begin
                row_sum_next = (sum_wide > (pctc_pkg::SUM_W+1)'(pctc_pkg::TWO_SUM))
                             ? pctc_pkg::TWO_SUM : sum_wide[pctc_pkg::SUM_W-1:0];
                if (row_end)
                begin
                    state_next = pctc_pkg::ST_DIAG_ROOT;
                end
                else
                begin
                    cur_col_next = cur_col_reg + 1'b1;
                    state_next   = pctc_pkg::ST_IDLE;
                end
            end
            pctc_pkg::ST_DIAG_ROOT:
            begin
                sqrt_start = 1'b1;
                state_next = pctc_pkg::ST_DIAG_WAIT;
            end
            pctc_pkg::ST_DIAG_WAIT:
            begin
                if (sqrt_done)
                    state_next = pctc_pkg::ST_EMIT_D;
            end
            pctc_pkg::ST_EMIT_D:
            begin
                if (out_free)
                begin
                    out_load                   = 1'b1;
                    out_data_next.factor_value = $signed(pctc_pkg::DATA_W'(sqrt_root));
                    out_data_next.row_index    = cur_row_reg;
                    out_data_next.col_index    = cur_row_reg;
                    out_data_next.last_of_run  = 1'b1;
                    out_data_next.matrix_done  = mat_end;
                    row_sum_next               = '0;
                    cur_col_next               = '0;
                    if (mat_end)
                    begin
                        cur_row_next     = pctc_pkg::IDX_W'(1);
                        origin_sent_next = 1'b0;
                    end
                    else
                    begin
                        cur_row_next = cur_row_reg + 1'b1;
                    end
                    state_next = pctc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pctc_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= pctc_pkg::ST_IDLE;
            dim_reg         <= pctc_pkg::DIM_MIN;
            row_sum_reg     <= '0;
            cur_row_reg     <= pctc_pkg::IDX_W'(1);
            cur_col_reg     <= '0;
            origin_sent_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            row_sum_reg     <= row_sum_next;
            cur_row_reg     <= cur_row_next;
            cur_col_reg     <= cur_col_next;
            origin_sent_reg <= origin_sent_next;
            if (cfg.valid && cfg.ready)
                dim_reg <= cfg.data.dimension;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (z_accept)
        begin
            neg_reg <= z_stream.data.z_value[pctc_pkg::DATA_W-1];
            // magnitude saturates at 1.0
            mag_reg <= (z_abs > pctc_pkg::DATA_W'(pctc_pkg::ONE_SUM))
                     ? pctc_pkg::ROOT_W'(pctc_pkg::ONE_SUM)
                     : z_abs[pctc_pkg::ROOT_W-1:0];
        end
        if (out_load)
            out_data_reg <= out_data_next;
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_sum_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        row_sum_reg <= pctc_pkg::TWO_SUM)
        else $error("row sum above 2.0");

    a_col_below_row: assert property (@(posedge clk) disable iff (!rst_n)
        cur_col_reg < cur_row_reg)
        else $error("column position not below row");

    a_root_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_done |-> (state_reg == pctc_pkg::ST_ROOT_WAIT ||
                       state_reg == pctc_pkg::ST_DIAG_WAIT))
        else $error("square root finished outside a wait state");

    a_matrix_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_data_next.matrix_done) |=>
            (!origin_sent_reg && cur_row_reg == pctc_pkg::IDX_W'(1)))
        else $error("matrix end did not rewind position");

endmodule
